// File: rtl/rdmc_pkg.sv
// Shared types and constants for the rover drive mode controller.
`timescale 1ns / 1ps

package rdmc_pkg;

  // Width of the autonomous phase tick counter.
  localparam int unsigned TIMER_BITS = 16;
  localparam int unsigned PHASE_TIME_W = 16;
  localparam int unsigned CMP_W = (TIMER_BITS > PHASE_TIME_W) ? TIMER_BITS : PHASE_TIME_W;

  localparam int unsigned DIST_W = 10;
  localparam int unsigned SPEED_W = 8;
  localparam int unsigned NUDGE_W = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Depth of the queue between the front and the back.
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [SPEED_W-1:0] NUDGE_SPEED_STRAIGHT = SPEED_W'(255);
  localparam logic [SPEED_W-1:0] NUDGE_SPEED_TURN = SPEED_W'(240);
  localparam logic [NUDGE_W-1:0] NUDGE_TURN_TICKS = NUDGE_W'(80);

  // Command bytes.
  localparam logic [7:0] CH_FWD = 8'h46;
  localparam logic [7:0] CH_BACK = 8'h42;
  localparam logic [7:0] CH_LEFT = 8'h4C;
  localparam logic [7:0] CH_RIGHT = 8'h52;
  localparam logic [7:0] CH_STOP = 8'h53;
  localparam logic [7:0] CH_AUTO = 8'h58;
  localparam logic [7:0] CH_FAN_ON = 8'h4F;
  localparam logic [7:0] CH_FAN_OFF = 8'h50;
  localparam logic [7:0] CH_FAN_TGL = 8'h56;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FWD_SPEED = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REV_SPEED = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_SPEED = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_TIME = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BACK_TIME = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_TIME = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_NUDGE_TIME = 3'd7;

  typedef enum logic [1:0] {
    WHEEL_STOP = 2'd0,
    WHEEL_FWD  = 2'd1,
    WHEEL_REV  = 2'd2
  } wheel_e;

  typedef enum logic [1:0] {
    PH_FORWARD = 2'd0,
    PH_CONFIRM = 2'd1,
    PH_REVERSE = 2'd2,
    PH_TURN    = 2'd3
  } phase_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_TICK,
    CMD_AUTO,
    CMD_STOP,
    CMD_FAN_ON,
    CMD_FAN_OFF,
    CMD_FAN_TGL,
    CMD_FWD,
    CMD_BACK,
    CMD_LEFT,
    CMD_RIGHT
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
    logic obstacle;
    logic rnd;
  } work_t;

  typedef struct packed {
    logic [DIST_W-1:0]       threshold;
    logic [SPEED_W-1:0]      fwd_speed;
    logic [SPEED_W-1:0]      rev_speed;
    logic [SPEED_W-1:0]      turn_speed;
    logic [PHASE_TIME_W-1:0] confirm_time;
    logic [PHASE_TIME_W-1:0] back_time;
    logic [PHASE_TIME_W-1:0] turn_time;
    logic [NUDGE_W-1:0]      nudge_time;
  } cfg_t;

endpackage

// File: rtl/rdmc_if.sv
// Valid/ready channel interfaces for input items and result items.
`timescale 1ns / 1ps

interface rdmc_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] command_char;
  logic [9:0] dist_a;
  logic [9:0] dist_b;
  logic [9:0] dist_c;
  logic       random_bit;

  modport source (
    output valid, op, command_char, dist_a, dist_b, dist_c, random_bit,
    input  ready
  );
  modport sink (
    input  valid, op, command_char, dist_a, dist_b, dist_c, random_bit,
    output ready
  );
endinterface

interface rdmc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] left_wheel;
  logic [1:0] right_wheel;
  logic [7:0] wheel_speed;
  logic       fan_on;
  logic       autonomous;
  logic [1:0] avoid_phase;

  modport source (
    output valid, left_wheel, right_wheel, wheel_speed, fan_on, autonomous, avoid_phase,
    input  ready
  );
  modport sink (
    input  valid, left_wheel, right_wheel, wheel_speed, fan_on, autonomous, avoid_phase,
    output ready
  );
endinterface

// File: rtl/rdmc_front.sv
// Front end: accepts input items, decodes commands and detects obstacles.
`timescale 1ns / 1ps

module rdmc_front (
  rdmc_in_if.sink                       in_i,
  input  logic [rdmc_pkg::DIST_W-1:0]   threshold_i,
  output rdmc_pkg::work_t               wrk_o,
  output logic                          wrk_valid_o,
  input  logic                          wrk_ready_i
);

  logic [rdmc_pkg::DIST_W-1:0] med;
  logic [rdmc_pkg::DIST_W-1:0] a, b, c;

  assign a = in_i.dist_a;
  assign b = in_i.dist_b;
  assign c = in_i.dist_c;

  always_comb begin
    if ((a <= b && b <= c) || (c <= b && b <= a)) begin
      med = b;
    end else if ((b <= a && a <= c) || (c <= a && a <= b)) begin
      med = a;
    end else begin
      med = c;
    end
  end

  always_comb begin
    wrk_o.rnd = in_i.random_bit;
    wrk_o.obstacle = (med != '0) && (med <= threshold_i);
    if (in_i.op) begin
      wrk_o.cmd = rdmc_pkg::CMD_TICK;
    end else begin
      unique case (in_i.command_char)
        rdmc_pkg::CH_FWD:     wrk_o.cmd = rdmc_pkg::CMD_FWD;
        rdmc_pkg::CH_BACK:    wrk_o.cmd = rdmc_pkg::CMD_BACK;
        rdmc_pkg::CH_LEFT:    wrk_o.cmd = rdmc_pkg::CMD_LEFT;
        rdmc_pkg::CH_RIGHT:   wrk_o.cmd = rdmc_pkg::CMD_RIGHT;
        rdmc_pkg::CH_STOP:    wrk_o.cmd = rdmc_pkg::CMD_STOP;
        rdmc_pkg::CH_AUTO:    wrk_o.cmd = rdmc_pkg::CMD_AUTO;
        rdmc_pkg::CH_FAN_ON:  wrk_o.cmd = rdmc_pkg::CMD_FAN_ON;
        rdmc_pkg::CH_FAN_OFF: wrk_o.cmd = rdmc_pkg::CMD_FAN_OFF;
        rdmc_pkg::CH_FAN_TGL: wrk_o.cmd = rdmc_pkg::CMD_FAN_TGL;
        default:              wrk_o.cmd = rdmc_pkg::CMD_NONE;
      endcase
    end
  end

  assign wrk_valid_o = in_i.valid;
  assign in_i.ready = wrk_ready_i;

endmodule

// File: rtl/rdmc_queue.sv
// Short queue of decoded items between the front and the back.
`timescale 1ns / 1ps

module rdmc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rdmc_pkg::work_t push_data_i,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  output rdmc_pkg::work_t pop_data_o,
  output logic            pop_valid_o,
  input  logic            pop_ready_i
);

  rdmc_pkg::work_t mem_q [rdmc_pkg::Q_DEPTH];
  logic [rdmc_pkg::Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [rdmc_pkg::Q_CNT_W-1:0] cnt_q, cnt_d;
  logic push, pop;

  assign push_ready_o = (cnt_q != rdmc_pkg::Q_CNT_W'(rdmc_pkg::Q_DEPTH));
  assign pop_valid_o = (cnt_q != '0);
  assign push = push_valid_i && push_ready_o;
  assign pop = pop_valid_o && pop_ready_i;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == rdmc_pkg::Q_PTR_W'(rdmc_pkg::Q_DEPTH - 1)) ? '0
               : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == rdmc_pkg::Q_PTR_W'(rdmc_pkg::Q_DEPTH - 1)) ? '0
               : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/rdmc_back.sv
// Back end: drive, fan and avoidance state, updated once per item.
`timescale 1ns / 1ps

module rdmc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rdmc_pkg::cfg_t  cfg_i,
  input  rdmc_pkg::work_t wrk_i,
  input  logic            wrk_valid_i,
  output logic            wrk_ready_o,
  rdmc_out_if.source      out_o
);

  logic out_valid_q, out_valid_d;
  logic auto_q, auto_d;
  rdmc_pkg::phase_e phase_q, phase_d;
  logic [rdmc_pkg::TIMER_BITS-1:0] ticks_q, ticks_d, ticks_inc;
  logic turn_right_q, turn_right_d;
  logic fan_q, fan_d;
  logic nudge_act_q, nudge_act_d;
  logic [rdmc_pkg::NUDGE_W-1:0] nudge_cnt_q, nudge_cnt_d;
  logic [rdmc_pkg::NUDGE_W-1:0] nudge_len_q, nudge_len_d;
  rdmc_pkg::wheel_e left_q, left_d, right_q, right_d;
  logic [rdmc_pkg::SPEED_W-1:0] speed_q, speed_d;
  logic [rdmc_pkg::CMP_W-1:0] ticks_ext;
  logic confirm_done, back_done, turn_done;
  logic pop;

  // The state registers are the result: a new item is only taken once the
  // previous result has been transferred.
  assign wrk_ready_o = !out_valid_q || out_o.ready;
  assign pop = wrk_valid_i && wrk_ready_o;

  assign ticks_inc = (ticks_q != '1) ? ticks_q + 1'b1 : ticks_q;
  assign ticks_ext = rdmc_pkg::CMP_W'(ticks_inc);
  assign confirm_done = ticks_ext >= rdmc_pkg::CMP_W'(cfg_i.confirm_time);
  assign back_done = ticks_ext >= rdmc_pkg::CMP_W'(cfg_i.back_time);
  assign turn_done = ticks_ext >= rdmc_pkg::CMP_W'(cfg_i.turn_time);

  always_comb begin
    out_valid_d = out_valid_q;
    auto_d = auto_q;
    phase_d = phase_q;
    ticks_d = ticks_q;
    turn_right_d = turn_right_q;
    fan_d = fan_q;
    nudge_act_d = nudge_act_q;
    nudge_cnt_d = nudge_cnt_q;
    nudge_len_d = nudge_len_q;
    left_d = left_q;
    right_d = right_q;
    speed_d = speed_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (pop) begin
      out_valid_d = 1'b1;
      unique case (wrk_i.cmd)
        rdmc_pkg::CMD_AUTO: begin
          auto_d = 1'b1;
          phase_d = rdmc_pkg::PH_FORWARD;
          ticks_d = '0;
          fan_d = 1'b1;
        end
        rdmc_pkg::CMD_STOP: begin
          auto_d = 1'b0;
          left_d = rdmc_pkg::WHEEL_STOP;
          right_d = rdmc_pkg::WHEEL_STOP;
          speed_d = '0;
        end
        rdmc_pkg::CMD_FAN_ON:  fan_d = 1'b1;
        rdmc_pkg::CMD_FAN_OFF: fan_d = 1'b0;
        rdmc_pkg::CMD_FAN_TGL: fan_d = !fan_q;
        rdmc_pkg::CMD_FWD, rdmc_pkg::CMD_BACK,
        rdmc_pkg::CMD_LEFT, rdmc_pkg::CMD_RIGHT: begin
          auto_d = 1'b0;
          nudge_act_d = 1'b1;
          nudge_cnt_d = '0;
          if (wrk_i.cmd == rdmc_pkg::CMD_FWD || wrk_i.cmd == rdmc_pkg::CMD_BACK) begin
            nudge_len_d = cfg_i.nudge_time;
            speed_d = rdmc_pkg::NUDGE_SPEED_STRAIGHT;
          end else begin
            nudge_len_d = rdmc_pkg::NUDGE_TURN_TICKS;
            speed_d = rdmc_pkg::NUDGE_SPEED_TURN;
          end
          left_d = (wrk_i.cmd == rdmc_pkg::CMD_FWD || wrk_i.cmd == rdmc_pkg::CMD_RIGHT)
                 ? rdmc_pkg::WHEEL_FWD : rdmc_pkg::WHEEL_REV;
          right_d = (wrk_i.cmd == rdmc_pkg::CMD_FWD || wrk_i.cmd == rdmc_pkg::CMD_LEFT)
                  ? rdmc_pkg::WHEEL_FWD : rdmc_pkg::WHEEL_REV;
        end
        rdmc_pkg::CMD_TICK: begin
          if (auto_q) begin
            ticks_d = ticks_inc;
            unique case (phase_q)
              rdmc_pkg::PH_FORWARD: begin
                if (wrk_i.obstacle) begin
                  left_d = rdmc_pkg::WHEEL_STOP;
                  right_d = rdmc_pkg::WHEEL_STOP;
                  speed_d = '0;
                  phase_d = rdmc_pkg::PH_CONFIRM;
                  ticks_d = '0;
                end else begin
                  left_d = rdmc_pkg::WHEEL_FWD;
                  right_d = rdmc_pkg::WHEEL_FWD;
                  speed_d = cfg_i.fwd_speed;
                end
              end
              rdmc_pkg::PH_CONFIRM: begin
                if (confirm_done) begin
                  if (wrk_i.obstacle) begin
                    turn_right_d = wrk_i.rnd;
                    left_d = rdmc_pkg::WHEEL_REV;
                    right_d = rdmc_pkg::WHEEL_REV;
                    speed_d = cfg_i.rev_speed;
                    phase_d = rdmc_pkg::PH_REVERSE;
                    ticks_d = '0;
                  end else begin
                    phase_d = rdmc_pkg::PH_FORWARD;
                  end
                end
              end
              rdmc_pkg::PH_REVERSE: begin
                if (back_done) begin
                  left_d = turn_right_q ? rdmc_pkg::WHEEL_FWD : rdmc_pkg::WHEEL_REV;
                  right_d = turn_right_q ? rdmc_pkg::WHEEL_REV : rdmc_pkg::WHEEL_FWD;
                  speed_d = cfg_i.turn_speed;
                  phase_d = rdmc_pkg::PH_TURN;
                  ticks_d = '0;
                end
              end
              rdmc_pkg::PH_TURN: begin
                if (turn_done) begin
                  phase_d = rdmc_pkg::PH_FORWARD;
                end
              end
              default: phase_d = phase_q;
            endcase
          end else if (nudge_act_q) begin
            if (nudge_cnt_q >= nudge_len_q) begin
              left_d = rdmc_pkg::WHEEL_STOP;
              right_d = rdmc_pkg::WHEEL_STOP;
              speed_d = '0;
              nudge_act_d = 1'b0;
            end else begin
              nudge_cnt_d = nudge_cnt_q + 1'b1;
            end
          end
        end
        default: begin
          // Unknown bytes still produce a result with unchanged state.
          out_valid_d = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      auto_q <= 1'b0;
      phase_q <= rdmc_pkg::PH_FORWARD;
      ticks_q <= '0;
      turn_right_q <= 1'b1;
      fan_q <= 1'b0;
      nudge_act_q <= 1'b0;
      nudge_cnt_q <= '0;
      nudge_len_q <= '0;
      left_q <= rdmc_pkg::WHEEL_STOP;
      right_q <= rdmc_pkg::WHEEL_STOP;
      speed_q <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      auto_q <= auto_d;
      phase_q <= phase_d;
      ticks_q <= ticks_d;
      turn_right_q <= turn_right_d;
      fan_q <= fan_d;
      nudge_act_q <= nudge_act_d;
      nudge_cnt_q <= nudge_cnt_d;
      nudge_len_q <= nudge_len_d;
      left_q <= left_d;
      right_q <= right_d;
      speed_q <= speed_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.left_wheel = left_q;
  assign out_o.right_wheel = right_q;
  assign out_o.wheel_speed = speed_q;
  assign out_o.fan_on = fan_q;
  assign out_o.autonomous = auto_q;
  assign out_o.avoid_phase = phase_q;

endmodule

// File: rtl/rover_drive_mode_controller_core.sv
// Top level of the rover drive mode controller: configuration, front, queue and back.
// Each transferred item is written into the queue; its result is registered by the back end.
// Throughput: one item per cycle unless out_o stalls; each item is one back-end state update.
// The two-entry queue lets the front keep taking items while a result waits.
// Reset (asynchronous, active low) returns all state to its idle values (right turn selected)
// and loads the register defaults.
`timescale 1ns / 1ps

module rover_drive_mode_controller_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [rdmc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rdmc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  rdmc_in_if.sink                            in_i,
  rdmc_out_if.source                         out_o
);

  rdmc_pkg::cfg_t  cfg_q, cfg_d;
  rdmc_pkg::work_t front_wrk, back_wrk;
  logic front_valid, front_ready, back_valid, back_ready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rdmc_pkg::CFG_THRESHOLD:    cfg_d.threshold = cfg_data_i[rdmc_pkg::DIST_W-1:0];
        rdmc_pkg::CFG_FWD_SPEED:    cfg_d.fwd_speed = cfg_data_i[rdmc_pkg::SPEED_W-1:0];
        rdmc_pkg::CFG_REV_SPEED:    cfg_d.rev_speed = cfg_data_i[rdmc_pkg::SPEED_W-1:0];
        rdmc_pkg::CFG_TURN_SPEED:   cfg_d.turn_speed = cfg_data_i[rdmc_pkg::SPEED_W-1:0];
        rdmc_pkg::CFG_CONFIRM_TIME: cfg_d.confirm_time = cfg_data_i;
        rdmc_pkg::CFG_BACK_TIME:    cfg_d.back_time = cfg_data_i;
        rdmc_pkg::CFG_TURN_TIME:    cfg_d.turn_time = cfg_data_i;
        rdmc_pkg::CFG_NUDGE_TIME:   cfg_d.nudge_time = cfg_data_i[rdmc_pkg::NUDGE_W-1:0];
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold <= rdmc_pkg::DIST_W'(15);
      cfg_q.fwd_speed <= rdmc_pkg::SPEED_W'(210);
      cfg_q.rev_speed <= rdmc_pkg::SPEED_W'(220);
      cfg_q.turn_speed <= rdmc_pkg::SPEED_W'(220);
      cfg_q.confirm_time <= rdmc_pkg::PHASE_TIME_W'(150);
      cfg_q.back_time <= rdmc_pkg::PHASE_TIME_W'(200);
      cfg_q.turn_time <= rdmc_pkg::PHASE_TIME_W'(150);
      cfg_q.nudge_time <= rdmc_pkg::NUDGE_W'(120);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rdmc_front u_front (
    .in_i        (in_i),
    .threshold_i (cfg_q.threshold),
    .wrk_o       (front_wrk),
    .wrk_valid_o (front_valid),
    .wrk_ready_i (front_ready)
  );

  rdmc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (front_wrk),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_data_o   (back_wrk),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready)
  );

  rdmc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .wrk_i       (back_wrk),
    .wrk_valid_i (back_valid),
    .wrk_ready_o (back_ready),
    .out_o       (out_o)
  );

`ifndef SYNTH
  // Stopped wheels always come with zero speed.
  a_stop_zero_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.left_wheel == rdmc_pkg::WHEEL_STOP
     && out_o.right_wheel == rdmc_pkg::WHEEL_STOP) |-> (out_o.wheel_speed == '0))
    else $error("stopped wheels with nonzero speed");

  // A wheel code is never the unused value.
  a_wheel_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.left_wheel != 2'd3 && out_o.right_wheel != 2'd3))
    else $error("invalid wheel code");

  // An item entering an empty pipeline produces a result through the queue and the back end.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && !back_valid && (!out_o.valid || out_o.ready))
    |-> ##2 out_o.valid)
    else $error("result missing after transfer into empty pipeline");
`endif

endmodule

// File: tb/rover_drive_checker.sv
// Checker that predicts every drive result of the rover controller and compares it.
`timescale 1ns / 1ps

module rover_drive_checker
  import rdmc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  rdmc_in_if                    in_i,
  rdmc_out_if                   out_i,
  output int unsigned           mismatches_o,
  output int unsigned           pending_o
);

  typedef struct packed {
    logic                  auto_on;
    phase_e                phase;
    logic [TIMER_BITS-1:0] ticks;
    logic                  turn_right;
    logic                  fan;
    logic                  nudging;
    logic [NUDGE_W-1:0]    nudge_cnt;
    logic [NUDGE_W-1:0]    nudge_len;
    wheel_e                left;
    wheel_e                right;
    logic [SPEED_W-1:0]    speed;
  } rover_t;

  typedef struct packed {
    logic [1:0]         left;
    logic [1:0]         right;
    logic [SPEED_W-1:0] speed;
    logic               fan;
    logic               auto_on;
    logic [1:0]         phase;
  } drive_view_t;

  localparam cfg_t REG_DEFAULTS = '{
    threshold:    10'd15,
    fwd_speed:    8'd210,
    rev_speed:    8'd220,
    turn_speed:   8'd220,
    confirm_time: 16'd150,
    back_time:    16'd200,
    turn_time:    16'd150,
    nudge_time:   8'd120
  };

  rover_t      rover;
  cfg_t        regs;
  drive_view_t want;
  drive_view_t seen;
  drive_view_t drive_expect_q[$];

  // One item's effect on the controller state.
  function automatic rover_t next_rover(input rover_t s, input cfg_t r, input logic is_tick,
                                        input logic [7:0] ch, input logic [DIST_W-1:0] da,
                                        input logic [DIST_W-1:0] db,
                                        input logic [DIST_W-1:0] dc, input logic rnd);
    rover_t            n;
    logic [DIST_W-1:0] lo;
    logic [DIST_W-1:0] hi;
    logic [DIST_W-1:0] mid;
    logic              blocked;
    n = s;
    if (!is_tick) begin
      case (ch)
        CH_AUTO: begin
          n.auto_on = 1'b1;
          n.phase = PH_FORWARD;
          n.ticks = '0;
          n.fan = 1'b1;
        end
        CH_STOP: begin
          n.auto_on = 1'b0;
          n.left = WHEEL_STOP;
          n.right = WHEEL_STOP;
          n.speed = '0;
        end
        CH_FAN_TGL: n.fan = !s.fan;
        CH_FAN_ON:  n.fan = 1'b1;
        CH_FAN_OFF: n.fan = 1'b0;
        CH_FWD, CH_BACK, CH_LEFT, CH_RIGHT: begin
          n.auto_on = 1'b0;
          n.nudging = 1'b1;
          n.nudge_cnt = '0;
          if (ch == CH_LEFT || ch == CH_RIGHT) begin
            n.nudge_len = NUDGE_TURN_TICKS;
            n.speed = NUDGE_SPEED_TURN;
          end else begin
            n.nudge_len = r.nudge_time;
            n.speed = NUDGE_SPEED_STRAIGHT;
          end
          if (ch == CH_FWD || ch == CH_RIGHT) n.left = WHEEL_FWD;
          else n.left = WHEEL_REV;
          if (ch == CH_FWD || ch == CH_LEFT) n.right = WHEEL_FWD;
          else n.right = WHEEL_REV;
        end
        default: ;
      endcase
    end else if (s.auto_on) begin
      lo = (da < db) ? da : db;
      hi = (da < db) ? db : da;
      mid = (dc < lo) ? lo : ((dc > hi) ? hi : dc);
      blocked = (mid != '0) && (mid <= r.threshold);
      if (n.ticks != '1) n.ticks = n.ticks + 1'b1;
      case (s.phase)
        PH_FORWARD: begin
          if (blocked) begin
            n.left = WHEEL_STOP;
            n.right = WHEEL_STOP;
            n.speed = '0;
            n.phase = PH_CONFIRM;
            n.ticks = '0;
          end else begin
            n.left = WHEEL_FWD;
            n.right = WHEEL_FWD;
            n.speed = r.fwd_speed;
          end
        end
        PH_CONFIRM: begin
          if (n.ticks >= r.confirm_time) begin
            if (blocked) begin
              n.turn_right = rnd;
              n.left = WHEEL_REV;
              n.right = WHEEL_REV;
              n.speed = r.rev_speed;
              n.phase = PH_REVERSE;
              n.ticks = '0;
            end else begin
              n.phase = PH_FORWARD;
            end
          end
        end
        PH_REVERSE: begin
          if (n.ticks >= r.back_time) begin
            if (s.turn_right) begin
              n.left = WHEEL_FWD;
              n.right = WHEEL_REV;
            end else begin
              n.left = WHEEL_REV;
              n.right = WHEEL_FWD;
            end
            n.speed = r.turn_speed;
            n.phase = PH_TURN;
            n.ticks = '0;
          end
        end
        default: begin
          if (n.ticks >= r.turn_time) n.phase = PH_FORWARD;
        end
      endcase
    end else if (s.nudging) begin
      if (s.nudge_cnt >= s.nudge_len) begin
        n.left = WHEEL_STOP;
        n.right = WHEEL_STOP;
        n.speed = '0;
        n.nudging = 1'b0;
      end else begin
        n.nudge_cnt = s.nudge_cnt + 1'b1;
      end
    end
    return n;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs = REG_DEFAULTS;
      rover = '0;
      rover.turn_right = 1'b1;
      drive_expect_q.delete();
      mismatches_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_THRESHOLD:    regs.threshold = cfg_data_i[DIST_W-1:0];
          CFG_FWD_SPEED:    regs.fwd_speed = cfg_data_i[SPEED_W-1:0];
          CFG_REV_SPEED:    regs.rev_speed = cfg_data_i[SPEED_W-1:0];
          CFG_TURN_SPEED:   regs.turn_speed = cfg_data_i[SPEED_W-1:0];
          CFG_CONFIRM_TIME: regs.confirm_time = cfg_data_i[PHASE_TIME_W-1:0];
          CFG_BACK_TIME:    regs.back_time = cfg_data_i[PHASE_TIME_W-1:0];
          CFG_TURN_TIME:    regs.turn_time = cfg_data_i[PHASE_TIME_W-1:0];
          CFG_NUDGE_TIME:   regs.nudge_time = cfg_data_i[NUDGE_W-1:0];
          default: ;
        endcase
      end

      if (in_i.valid && in_i.ready) begin
        rover = next_rover(rover, regs, in_i.op, in_i.command_char, in_i.dist_a,
                           in_i.dist_b, in_i.dist_c, in_i.random_bit);
        want.left = rover.left;
        want.right = rover.right;
        want.speed = rover.speed;
        want.fan = rover.fan;
        want.auto_on = rover.auto_on;
        want.phase = rover.phase;
        drive_expect_q.push_back(want);
      end

      if (out_i.valid && out_i.ready) begin
        seen.left = out_i.left_wheel;
        seen.right = out_i.right_wheel;
        seen.speed = out_i.wheel_speed;
        seen.fan = out_i.fan_on;
        seen.auto_on = out_i.autonomous;
        seen.phase = out_i.avoid_phase;
        if (drive_expect_q.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= 10) begin
            $display("%0t: result transfer with nothing expected", $realtime);
          end
        end else begin
          want = drive_expect_q.pop_front();
          if (seen !== want) begin
            mismatches_o++;
            if (mismatches_o <= 10) begin
              $display("%0t: mismatch left %0d/%0d right %0d/%0d speed %0d/%0d",
                       $realtime, want.left, seen.left, want.right, seen.right,
                       want.speed, seen.speed);
              $display("    fan %0d/%0d auto %0d/%0d phase %0d/%0d (expected/actual)",
                       want.fan, seen.fan, want.auto_on, seen.auto_on,
                       want.phase, seen.phase);
            end
          end
        end
      end
    end
    pending_o = drive_expect_q.size();
  end

endmodule

// File: tb/rover_drive_mode_controller_core_tb.sv
// Stimulus and verdict for the rover drive mode controller, with the checker beside the block.
`timescale 1ns / 1ps

module rover_drive_mode_controller_core_tb;
  import rdmc_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS = 250;
  localparam int unsigned LONG_HOLD = 60;
  localparam logic OP_CMD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum int unsigned {SET_RANDOM, SET_MIN, SET_MAX, SET_DIRECTED} setting_e;
  typedef enum int unsigned {DIST_NEAR, DIST_FAR, DIST_ZERO, DIST_ANY} dist_kind_e;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int unsigned           mismatches;
  int unsigned           pending;
  logic                  idle_en = 1'b1;
  logic                  hold_req = 1'b0;
  logic                  in_auto = 1'b0;
  logic [DIST_W-1:0]     cur_thr = 10'd15;

  rdmc_in_if  in_if ();
  rdmc_out_if out_if ();

  rover_drive_mode_controller_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  rover_drive_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_i         (in_if),
    .out_i        (out_if),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offers one item, possibly after an idle burst, and returns at the edge of its transfer.
  task automatic put_item(input logic op, input logic [7:0] ch, input logic [DIST_W-1:0] da,
                          input logic [DIST_W-1:0] db, input logic [DIST_W-1:0] dc,
                          input logic rnd);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.op <= op;
    in_if.command_char <= ch;
    in_if.dist_a <= da;
    in_if.dist_b <= db;
    in_if.dist_c <= dc;
    in_if.random_bit <= rnd;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic send_cmd(input logic [7:0] ch);
    if (ch == CH_AUTO) in_auto = 1'b1;
    else if (ch == CH_FWD || ch == CH_BACK || ch == CH_LEFT || ch == CH_RIGHT || ch == CH_STOP)
      in_auto = 1'b0;
    put_item(OP_CMD, ch, 10'($urandom), 10'($urandom), 10'($urandom), 1'($urandom));
  endtask

  task automatic send_tick(input logic [DIST_W-1:0] da, input logic [DIST_W-1:0] db,
                           input logic [DIST_W-1:0] dc, input logic rnd);
    put_item(OP_TICK, 8'($urandom), da, db, dc, rnd);
  endtask

  function automatic logic [DIST_W-1:0] pick_dist(input dist_kind_e kind);
    case (kind)
      DIST_NEAR: return (cur_thr == '0) ? '0 : 10'($urandom_range(1, cur_thr));
      DIST_FAR:  return (cur_thr == '1) ? '1 : 10'($urandom_range(int'(cur_thr) + 1, 1023));
      DIST_ZERO: return '0;
      default:   return ($urandom_range(0, 3) == 0) ? 10'd999 : 10'($urandom_range(0, 1023));
    endcase
  endfunction

  // Two samples share a class, so the median usually lands in it; the third is an outlier.
  task automatic send_random_tick();
    dist_kind_e        kind;
    logic [DIST_W-1:0] d [3];
    int unsigned       roll;
    int unsigned       odd;
    roll = $urandom_range(0, 9);
    if (roll < 4) kind = DIST_NEAR;
    else if (roll < 8) kind = DIST_FAR;
    else if (roll == 8) kind = DIST_ZERO;
    else kind = DIST_ANY;
    odd = $urandom_range(0, 2);
    for (int i = 0; i < 3; i++) d[i] = pick_dist((i == odd) ? DIST_ANY : kind);
    send_tick(d[0], d[1], d[2], 1'($urandom));
  endtask

  task automatic send_random_cmd();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (!in_auto && $urandom_range(0, 2) == 0) pick = 0;
    case (pick)
      0: send_cmd(CH_AUTO);
      1: send_cmd(CH_STOP);
      2: send_cmd(CH_FAN_ON);
      3: send_cmd(CH_FAN_OFF);
      4: send_cmd(CH_FAN_TGL);
      5: send_cmd(CH_FWD);
      6: send_cmd(CH_BACK);
      7: send_cmd(CH_LEFT);
      8: send_cmd(CH_RIGHT);
      default: send_cmd(8'($urandom));
    endcase
  endtask

  // Lets every expected result drain, then idles so the pipeline can empty.
  task automatic settle();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // Sometimes sets the bits above a register's width; the block drops them.
  function automatic logic [CFG_DATA_W-1:0] widen(input logic [CFG_DATA_W-1:0] v,
                                                  input int unsigned w);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom) << w;
    return ($urandom_range(0, 3) == 0) ? (v | junk) : v;
  endfunction

  task automatic program_regs(input setting_e style);
    logic [DIST_W-1:0]       thr;
    logic [SPEED_W-1:0]      fs;
    logic [SPEED_W-1:0]      rs;
    logic [SPEED_W-1:0]      ts;
    logic [PHASE_TIME_W-1:0] ct;
    logic [PHASE_TIME_W-1:0] bt;
    logic [PHASE_TIME_W-1:0] tt;
    logic [NUDGE_W-1:0]      nt;
    case (style)
      SET_MIN: begin
        thr = '0; fs = '0; rs = '0; ts = '0;
        ct = '0; bt = '0; tt = '0; nt = '0;
      end
      SET_MAX: begin
        thr = '1; fs = '1; rs = '1; ts = '1;
        ct = '1; bt = '1; tt = '1; nt = '1;
      end
      SET_DIRECTED: begin
        thr = 10'd100; fs = 8'd200; rs = 8'd180; ts = 8'd160;
        ct = 16'd2; bt = 16'd2; tt = 16'd2; nt = 8'd3;
      end
      default: begin
        thr = 10'($urandom_range(20, 700));
        fs = 8'($urandom); rs = 8'($urandom); ts = 8'($urandom);
        ct = 16'($urandom_range(0, 12));
        bt = 16'($urandom_range(0, 12));
        tt = 16'($urandom_range(0, 12));
        nt = 8'($urandom_range(0, 15));
      end
    endcase
    cur_thr = thr;
    write_reg(CFG_THRESHOLD, widen(CFG_DATA_W'(thr), DIST_W));
    write_reg(CFG_FWD_SPEED, widen(CFG_DATA_W'(fs), SPEED_W));
    write_reg(CFG_REV_SPEED, widen(CFG_DATA_W'(rs), SPEED_W));
    write_reg(CFG_TURN_SPEED, widen(CFG_DATA_W'(ts), SPEED_W));
    write_reg(CFG_CONFIRM_TIME, ct);
    write_reg(CFG_BACK_TIME, bt);
    write_reg(CFG_TURN_TIME, tt);
    write_reg(CFG_NUDGE_TIME, widen(CFG_DATA_W'(nt), NUDGE_W));
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input setting_e style, input logic quiet);
    program_regs(style);
    for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
      if (k % 50 == 0) idle_en = !quiet && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 99) < (in_auto ? 3 : 12)) send_random_cmd();
      else send_random_tick();
    end
    settle();
  endtask

  // Result side: short random stalls, plus one long hold-off on request.
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left = 0;
    hold_left = 0;
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 5) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("rover_drive_mode_controller_core_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    rst_n = 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= '0;
    cfg_data <= '0;
    in_if.valid <= 1'b0;
    in_if.op <= OP_CMD;
    in_if.command_char <= '0;
    in_if.dist_a <= '0;
    in_if.dist_b <= '0;
    in_if.dist_c <= '0;
    in_if.random_bit <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Register defaults: forward speed, then an obstacle at the default threshold.
    send_cmd(CH_AUTO);
    send_tick(10'd500, 10'd500, 10'd500, 1'b1);
    send_tick(10'd10, 10'd12, 10'd999, 1'b1);
    settle();

    program_regs(SET_DIRECTED);
    send_cmd(8'h00);
    send_cmd(8'hFF);
    send_cmd(CH_FAN_OFF);
    send_cmd(CH_FAN_TGL);
    send_cmd(CH_FAN_ON);
    // Full avoidance pass with a left turn; out-of-range samples are compared as they are.
    send_tick(10'd50, 10'd60, 10'd1023, 1'b0);
    send_tick(10'd70, 10'd40, 10'd1023, 1'b0);
    repeat (4) send_tick(10'd999, 10'd999, 10'd999, 1'b1);
    // A zero median is no obstacle; a median equal to the threshold is one.
    send_tick(10'd0, 10'd0, 10'd700, 1'b0);
    send_tick(10'd100, 10'd1023, 10'd100, 1'b0);
    // Obstacle gone at confirmation: back to forward with the motors stopped.
    repeat (2) send_tick(10'd999, 10'd999, 10'd999, 1'b1);
    // Straight nudge runs out on the tick after its length.
    send_cmd(CH_FWD);
    repeat (4) send_tick(10'd0, 10'd0, 10'd0, 1'b0);
    send_cmd(CH_BACK);
    send_cmd(CH_LEFT);
    send_cmd(CH_RIGHT);
    send_tick(10'd5, 10'd5, 10'd5, 1'b0);
    send_cmd(CH_STOP);
    send_tick(10'd5, 10'd5, 10'd5, 1'b0);
    settle();

    run_phase(SET_RANDOM, 1'b0);
    run_phase(SET_MIN, 1'b0);
    hold_req = 1'b1;
    run_phase(SET_RANDOM, 1'b0);
    run_phase(SET_MAX, 1'b0);
    run_phase(SET_RANDOM, 1'b0);
    run_phase(SET_RANDOM, 1'b0);
    run_phase(SET_RANDOM, 1'b1);

    if (mismatches == 0) begin
      $display("rover_drive_mode_controller_core_tb: PASS");
    end else begin
      $display("rover_drive_mode_controller_core_tb: FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/rdmc_pkg.sv
rtl/rdmc_if.sv
rtl/rdmc_front.sv
rtl/rdmc_queue.sv
rtl/rdmc_back.sv
rtl/rover_drive_mode_controller_core.sv
tb/rover_drive_checker.sv
tb/rover_drive_mode_controller_core_tb.sv
